// ----- rtl/m3i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

	localparam int ENTRY_WIDTH = 16;
	localparam int FRAC_BITS   = 8;
	localparam int OUT_FRAC    = 16;
	localparam int OUT_W       = 32;
	localparam int N_ENTRY     = 9;

	// exact widths of the intermediate terms
	localparam int PROD_W  = 2 * ENTRY_WIDTH;
	localparam int COF_W   = PROD_W + 1;
	localparam int TERM_W  = ENTRY_WIDTH + COF_W;
	localparam int DET_W   = TERM_W + 1;
	localparam int DMAG_W  = DET_W - 1;
	localparam int CMAG_W  = COF_W - 1;

	// scaled numerator |C| * 2^(FRAC_BITS+OUT_FRAC), split at bit OUT_W
	localparam int SHIFT_N = FRAC_BITS + OUT_FRAC;
	localparam int NUM_W   = CMAG_W + SHIFT_N;
	localparam int NHI_W   = NUM_W - OUT_W;
	localparam int REM_W   = DMAG_W + 1;
	localparam int DIV_STEPS = OUT_W;

	localparam int IN_DATA_W  = ((N_ENTRY * ENTRY_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = N_ENTRY * OUT_W;
	localparam int OUT_USER_W = 2;

	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

	typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
	typedef logic signed [COF_W-1:0]       cof_t;
	typedef logic signed [DET_W-1:0]       det_t;

	// work handed from the front to the back
	typedef struct packed {
		cof_t [N_ENTRY-1:0] cof;
		det_t               det;
	} fq_item_t;

endpackage
`default_nettype wire

// ----- rtl/matrix3x3_inverse.sv -----
// Pipeline from input acceptance to result, with no stall:
//   4 front stages, 1 queue slot, prep, 32 divide steps, round/output register.
// Throughput: one matrix per cycle while neither side stalls; the 32-step pipelined divider lanes set it.
// Front and back stall separately through a 4-entry queue.
// Reset: arst_n clears all valid flags and queue pointers at once; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, 16 bits each
	input  wire logic [m3i_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// out_r0c0, out_r0c1, out_r0c2, out_r1c0 .. out_r2c2, 32 bits each
	output logic [m3i_pkg::OUT_DATA_W-1:0]      m_tdata,
	// singular, overflow
	output logic [m3i_pkg::OUT_USER_W-1:0]      m_tuser
);
	import m3i_pkg::*;

	fq_item_t f_item;
	fq_item_t q_item;
	logic     f_valid;
	logic     f_ready;
	logic     q_valid;
	logic     q_ready;

	m3i_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	m3i_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	m3i_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
`default_nettype wire

// ----- rtl/m3i_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module m3i_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [m3i_pkg::IN_DATA_W-1:0] in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output m3i_pkg::fq_item_t                  out_item
);
	import m3i_pkg::*;

	entry_t                a [N_ENTRY];
	logic signed [PROD_W-1:0] pa_s1 [N_ENTRY];
	logic signed [PROD_W-1:0] pb_s1 [N_ENTRY];
	entry_t                a0_s1 [3];
	entry_t                a0_s2 [3];
	cof_t                  cof_s2 [N_ENTRY];
	cof_t                  cof_s3 [N_ENTRY];
	cof_t                  cof_s4 [N_ENTRY];
	logic signed [TERM_W-1:0] t_s3 [3];
	det_t                  det_s4;
	logic [3:0]            vld_q;
	logic                  en;

	// advance the whole pipe unless the last stage is held
	assign en       = !vld_q[3] || out_ready;
	assign in_ready = en;

	genvar g;
	generate
		for (g = 0; g < N_ENTRY; g++) begin : g_unpack
			assign a[g] = in_data[g*ENTRY_WIDTH +: ENTRY_WIDTH];
		end
	endgenerate

	// cofactor products: entry (i,j) is component i of row j+1 cross row j+2
	generate
		for (g = 0; g < N_ENTRY; g++) begin : g_prod
			localparam int I = g / 3;
			localparam int J = g % 3;
			localparam int U = (J + 1) % 3;
			localparam int V = (J + 2) % 3;
			localparam int P = (I + 1) % 3;
			localparam int S = (I + 2) % 3;
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[g] <= a[U*3+P] * a[V*3+S];
					pb_s1[g] <= a[U*3+S] * a[V*3+P];
				end
			end
		end
	endgenerate

	// difference, determinant terms, determinant sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a0_s1[k] <= a[k];
				a0_s2[k] <= a0_s1[k];
				t_s3[k]  <= a0_s2[k] * cof_s2[k*3];
			end
			for (int k = 0; k < N_ENTRY; k++) begin
				cof_s2[k] <= COF_W'(pa_s1[k]) - COF_W'(pb_s1[k]);
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
			end
			det_s4 <= DET_W'(t_s3[0]) + DET_W'(t_s3[1]) + DET_W'(t_s3[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	assign out_valid = vld_q[3];
	always_comb begin
		for (int k = 0; k < N_ENTRY; k++) out_item.cof[k] = cof_s4[k];
		out_item.det = det_s4;
	end

endmodule
`default_nettype wire

// ----- rtl/m3i_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module m3i_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire m3i_pkg::fq_item_t wr_item,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output m3i_pkg::fq_item_t      rd_item
);
	import m3i_pkg::*;

	fq_item_t            mem [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q;
	logic [FQ_PTR_W-1:0] rd_ptr_q;
	logic [FQ_PTR_W:0]   cnt_q;
	logic                push;
	logic                pop;

	assign wr_ready = cnt_q != (FQ_PTR_W+1)'(FQ_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem[rd_ptr_q];

	// store item
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_item;
	end

	// move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/m3i_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module m3i_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire m3i_pkg::fq_item_t              in_item,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [m3i_pkg::OUT_DATA_W-1:0]      out_data,
	output logic [m3i_pkg::OUT_USER_W-1:0]      out_user
);
	import m3i_pkg::*;

	localparam int NST = DIV_STEPS + 1;

	// stage 0 is the sign/magnitude prep, stages 1..DIV_STEPS the divide steps
	logic [REM_W-1:0]  rem_q  [NST][N_ENTRY];
	logic [OUT_W-1:0]  quo_q  [NST][N_ENTRY];
	logic [OUT_W-1:0]  nlo_q  [NST][N_ENTRY];
	logic              neg_q  [NST][N_ENTRY];
	logic              ohi_q  [NST][N_ENTRY];
	logic [DMAG_W-1:0] den_q  [NST];
	logic              sing_q [NST];
	logic [NST:0]      vld_q;

	logic [REM_W-1:0]  rem_nx [NST][N_ENTRY];
	logic [OUT_W-1:0]  quo_nx [NST][N_ENTRY];
	logic [DMAG_W-1:0] dmag;
	logic [CMAG_W-1:0] cmag   [N_ENTRY];
	logic [NUM_W-1:0]  num    [N_ENTRY];
	logic              en;

	assign en        = !vld_q[NST] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NST];

	// magnitudes and scaled numerators
	always_comb begin
		dmag = in_item.det[DET_W-1] ? DMAG_W'(-in_item.det) : DMAG_W'(in_item.det);
		for (int k = 0; k < N_ENTRY; k++) begin
			cmag[k] = in_item.cof[k][COF_W-1] ? CMAG_W'(-in_item.cof[k])
			                                  : CMAG_W'(in_item.cof[k]);
			num[k]  = {cmag[k], {SHIFT_N{1'b0}}};
		end
	end

	// one restoring step per stage and lane
	always_comb begin
		logic [REM_W-1:0] t;
		logic             ge;
		for (int s = 0; s < NST; s++) begin
			for (int k = 0; k < N_ENTRY; k++) begin
				t  = {rem_q[s][k][REM_W-2:0], nlo_q[s][k][OUT_W-1]};
				ge = t >= {1'b0, den_q[s]};
				rem_nx[s][k] = ge ? t - {1'b0, den_q[s]} : t;
				quo_nx[s][k] = {quo_q[s][k][OUT_W-2:0], ge};
			end
		end
	end

	// advance prep and divide stages
	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0]  <= dmag;
			sing_q[0] <= in_item.det == '0;
			for (int k = 0; k < N_ENTRY; k++) begin
				rem_q[0][k] <= REM_W'(num[k][NUM_W-1:OUT_W]);
				nlo_q[0][k] <= num[k][OUT_W-1:0];
				quo_q[0][k] <= '0;
				neg_q[0][k] <= in_item.cof[k][COF_W-1] != in_item.det[DET_W-1];
				ohi_q[0][k] <= {{(DMAG_W-NHI_W){1'b0}}, num[k][NUM_W-1:OUT_W]} >= dmag;
			end
			for (int s = 1; s < NST; s++) begin
				den_q[s]  <= den_q[s-1];
				sing_q[s] <= sing_q[s-1];
				for (int k = 0; k < N_ENTRY; k++) begin
					rem_q[s][k] <= rem_nx[s-1][k];
					quo_q[s][k] <= quo_nx[s-1][k];
					nlo_q[s][k] <= {nlo_q[s-1][k][OUT_W-2:0], 1'b0};
					neg_q[s][k] <= neg_q[s-1][k];
					ohi_q[s][k] <= ohi_q[s-1][k];
				end
			end
		end
	end

	// round half away, saturate, restore sign into the output register
	always_ff @(posedge clk) begin
		logic             up;
		logic [OUT_W:0]   qr;
		logic [OUT_W:0]   lim;
		logic             sat;
		logic [OUT_W-1:0] mag;
		logic             any_sat;
		if (en) begin
			any_sat = 1'b0;
			for (int k = 0; k < N_ENTRY; k++) begin
				up  = {rem_q[DIV_STEPS][k], 1'b0} >= {2'b00, den_q[DIV_STEPS]};
				qr  = {1'b0, quo_q[DIV_STEPS][k]} + (OUT_W+1)'(up);
				lim = neg_q[DIV_STEPS][k] ? (OUT_W+1)'(1) << (OUT_W-1)
				                          : ((OUT_W+1)'(1) << (OUT_W-1)) - 1'b1;
				sat = ohi_q[DIV_STEPS][k] || qr > lim;
				mag = sat ? lim[OUT_W-1:0] : qr[OUT_W-1:0];
				any_sat = any_sat || sat;
				if (sing_q[DIV_STEPS]) out_data[k*OUT_W +: OUT_W] <= '0;
				else out_data[k*OUT_W +: OUT_W] <= neg_q[DIV_STEPS][k] ? -mag : mag;
			end
			out_user <= {any_sat && !sing_q[DIV_STEPS], sing_q[DIV_STEPS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:0], in_valid};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/m3i_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module m3i_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [m3i_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [m3i_pkg::OUT_USER_W-1:0] m_tuser
);

	// a singular result never reports saturation
	a_sing_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("singular result with overflow set");

	// a singular result carries all-zero entries
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("singular result with nonzero entries");

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind matrix3x3_inverse m3i_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ----- sim/matrix3x3_inverse_tb.sv -----
`timescale 1ns / 1ps
module matrix3x3_inverse_tb;
	import m3i_pkg::*;

	localparam int LATENCY = 39;

	typedef struct {
		logic [OUT_DATA_W-1:0] ent;
		logic                  singular;
		logic                  overflow;
	} inverse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	inverse_t pending_inv[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	always #6 clk = ~clk;

	matrix3x3_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// round |n|*2^24/|d| to nearest, ties away, saturate to Q16.16
	function automatic logic [31:0] div_q16(logic signed [127:0] num, logic signed [127:0] den,
			inout logic ovf);
		logic neg;
		logic [127:0] n, d, q, r;
		logic [31:0] lim;
		neg = num[127] ^ den[127];
		n = num[127] ? -num : num;
		d = den[127] ? -den : den;
		n = n << (FRAC_BITS + OUT_FRAC);
		q = n / d;
		r = n % d;
		if ((r << 1) >= d)
			q = q + 1;
		lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		if (q > {96'd0, lim}) begin
			q = {96'd0, lim};
			ovf = 1'b1;
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic inverse_t invert_matrix(logic [IN_DATA_W-1:0] data);
		logic signed [127:0] a[3][3];
		logic signed [127:0] det, cof;
		inverse_t res;
		logic ovf;
		int p, s, u, v;
		ovf = 1'b0;
		for (int i = 0; i < 9; i++)
			a[i/3][i%3] = 128'(signed'(data[i*ENTRY_WIDTH +: ENTRY_WIDTH]));
		det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
			- a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2] - a[0][2]*a[1][1]*a[2][0];
		res.ent = '0;
		res.singular = (det == 0);
		if (det != 0) begin
			for (int j = 0; j < 3; j++) begin
				u = (j + 1) % 3;
				v = (j + 2) % 3;
				for (int i = 0; i < 3; i++) begin
					p = (i + 1) % 3;
					s = (i + 2) % 3;
					cof = a[u][p]*a[v][s] - a[u][s]*a[v][p];
					res.ent[(i*3+j)*OUT_W +: OUT_W] = div_q16(cof, det, ovf);
				end
			end
		end
		res.overflow = ovf;
		return res;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_matrix(int e[9]);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		for (int i = 0; i < 9; i++)
			d[i*ENTRY_WIDTH +: ENTRY_WIDTH] = e[i][ENTRY_WIDTH-1:0];
		return d;
	endfunction

	// offer one matrix, holding it until accepted; queue its expected inverse
	task automatic send_matrix(logic [IN_DATA_W-1:0] data, logic typed, inverse_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_inv.push_back(typed ? want : invert_matrix(data));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_inv.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	// receiver: random stalls, plus a long counted hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// check each delivered inverse against the oldest expectation
	always @(posedge clk) begin
		inverse_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_inv.size() == 0) begin
				$display("%0t: unexpected result data=%h user=%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_inv.pop_front();
				for (int i = 0; i < N_ENTRY; i++)
					if (m_tdata[i*OUT_W +: OUT_W] !== want.ent[i*OUT_W +: OUT_W]) begin
						$display("%0t: entry %0d expected %h actual %h", $time, i,
							want.ent[i*OUT_W +: OUT_W], m_tdata[i*OUT_W +: OUT_W]);
						errors++;
					end
				if (m_tuser[0] !== want.singular) begin
					$display("%0t: singular expected %b actual %b", $time,
						want.singular, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time,
						want.overflow, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	typedef struct {
		int       e[9];
		logic     typed;
		inverse_t want;
	} stim_row_t;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		inverse_t ident, zero_sing;
		int e[9];
		int mode;
		logic [IN_DATA_W-1:0] d;

		ident.ent = '0;
		ident.ent[0*OUT_W +: OUT_W] = ONE_Q16;
		ident.ent[4*OUT_W +: OUT_W] = ONE_Q16;
		ident.ent[8*OUT_W +: OUT_W] = ONE_Q16;
		ident.singular = 1'b0;
		ident.overflow = 1'b0;
		zero_sing.ent = '0;
		zero_sing.singular = 1'b1;
		zero_sing.overflow = 1'b0;

		// directed table: typed rows where the answer is obvious, the rest computed by invert_matrix
		rows.push_back('{'{256, 0, 0, 0, 256, 0, 0, 0, 256}, 1'b1, ident});
		rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, zero_sing});
		rows.push_back('{'{256, 512, 768, 256, 512, 768, 1, 2, 3}, 1'b1, zero_sing});
		rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768}, 1'b1, zero_sing});
		rows.push_back('{'{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}, 1'b0, ident});
		rows.push_back('{'{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}, 1'b0, ident});
		rows.push_back('{'{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, ident});
		rows.push_back('{'{-1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, ident});
		rows.push_back('{'{32767, -32768, 32767, -32768, 32767, -32768, 1, 0, -1}, 1'b0, ident});
		rows.push_back('{'{32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767},
			1'b0, ident});
		rows.push_back('{'{0, 256, 0, 0, 0, 256, 256, 0, 0}, 1'b0, ident});
		rows.push_back('{'{512, 0, 0, 0, 768, 0, 0, 0, 3}, 1'b0, ident});
		rows.push_back('{'{1, 1, 0, 0, 1, 1, 1, 0, 1}, 1'b0, ident});
		rows.push_back('{'{-21846, 21845, 12345, 1, -1, 3, 7, 255, -256}, 1'b0, ident});

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[k])
			send_matrix(pack_matrix(rows[k].e), rows[k].typed, rows[k].want);
		drain();

		for (int n = 0; n < 1100; n++) begin
			case (n / 220)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
				3: begin send_idle_pct = 31; recv_stall_pct = 31; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			// long receiver hold-off so the queue fills and input stalls
			if (n == 900)
				hold_cycles = 150;
			// sender waits for all outstanding results
			if (n == 1000 || n == 440)
				drain();
			mode = $urandom_range(9);
			for (int i = 0; i < 9; i++) begin
				case (mode)
					0: e[i] = $urandom_range(1) ? 32767 : -32768;
					1: e[i] = $signed($urandom_range(6)) - 3;
					2: e[i] = $signed($urandom_range(1024)) - 512;
					default: e[i] = $signed(16'($urandom()));
				endcase
			end
			// make some rows dependent to hit singular matrices
			if (mode == 3)
				for (int i = 0; i < 3; i++)
					e[6+i] = e[i];
			d = pack_matrix(e);
			send_matrix(d, 1'b0, zero_sing);
		end
		drain();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_queue.sv
rtl/m3i_back.sv
rtl/matrix3x3_inverse.sv
rtl/m3i_checker.sv
sim/matrix3x3_inverse_tb.sv
